FILE: rtl/binary_majority_filter_3x3_unit_defines.svh
// Assertion macros shared by the majority filter RTL.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef BINARY_MAJORITY_FILTER_3X3_UNIT_DEFINES_SVH
`define BINARY_MAJORITY_FILTER_3X3_UNIT_DEFINES_SVH

// Condition that must hold at every clock edge out of reset
`define BMF_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Condition that must hold in the cycle after a trigger
`define BMF_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) else $error(msg);

`endif

FILE: rtl/bmf_pkg.sv
// Package for the 3x3 binary majority filter: types, codes, constants.
// No dependencies.
`timescale 1ns / 1ps

package bmf_pkg;

  // Item command codes
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  // Configuration register map
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;
  localparam int WIDTH_FIELD_W  = 11;
  localparam int HEIGHT_FIELD_W = 7;
  localparam int WIDTH_RST  = 1024;
  localparam int HEIGHT_RST = 64;

  // Window geometry
  localparam int WIN_DIM  = 3;
  localparam int WIN_BITS = WIN_DIM * WIN_DIM;
  localparam int CNT_W    = 4;

  // Decoded item handed from the scan counters to the window stage
  typedef struct packed {
    logic value;  // source pixel, zero once the frame is in
    logic col0;   // item sits in column 0 of the input raster
    logic emit;   // item releases one filtered pixel
    logic fend;   // item releases the last pixel of the frame
  } item_t;

  // Clamp a dimension to 1..lim and return it minus one
  function automatic logic [31:0] dim_last(logic [31:0] v, logic [31:0] lim);
    logic [31:0] e;
    e = (v == 32'd0) ? 32'd1 : ((v > lim) ? lim : v);
    return e - 32'd1;
  endfunction

endpackage

FILE: rtl/bmf_in_if.sv
// Input channel of the majority filter: valid/ready plus one pixel item.
// Depends on nothing.
`timescale 1ns / 1ps

interface bmf_in_if;
  logic valid;
  logic ready;
  logic cmd;
  logic pixel_in;

  modport source (output valid, output cmd, output pixel_in, input ready);
  modport sink   (input valid, input cmd, input pixel_in, output ready);
endinterface

FILE: rtl/bmf_out_if.sv
// Result channel of the majority filter: valid/ready plus one filtered pixel.
// Depends on nothing.
`timescale 1ns / 1ps

interface bmf_out_if;
  logic valid;
  logic ready;
  logic pixel_out;
  logic row_end;
  logic frame_end;

  modport source (output valid, output pixel_out, output row_end, output frame_end,
                  input ready);
  modport sink   (input valid, input pixel_out, input row_end, input frame_end,
                  output ready);
endinterface

FILE: rtl/bmf_line_mem.sv
// Two line stores (upper and middle row) sharing one write port and one
// registered read port, each port with its own address. No package dependency.
`timescale 1ns / 1ps

module bmf_line_mem #(
  parameter int DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [1:0]                             wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [1:0]                             rdata
);

  // bit 1 = upper line, bit 0 = middle line
  logic [1:0] mem [DEPTH];
  logic [1:0] q_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      q_r <= mem[raddr];
    end
  end

  assign rdata = q_r;

endmodule

FILE: rtl/bmf_scan.sv
// Configuration registers and input raster counters; decodes each item.
// Depends on bmf_pkg and bmf_in_if.
`timescale 1ns / 1ps

module bmf_scan #(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 64
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  bmf_in_if.sink                                       in_ch,
  input  logic                                         stage_free,
  input  logic                                         cfg_we,
  input  logic [bmf_pkg::CFG_IDX_W-1:0]                cfg_idx,
  input  logic [bmf_pkg::CFG_DATA_W-1:0]               cfg_wdata,
  output logic                                         load,
  output bmf_pkg::item_t                               item,
  output logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] addr,
  output logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] w_last,
  output logic [$clog2(MAX_ROWS + 2)-1:0]              h_last
);

  localparam int AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RW = $clog2(MAX_ROWS + 2);

  logic [AW-1:0] w_last_r, w_last_nxt;
  logic [RW-1:0] h_last_r, h_last_nxt;
  logic [AW-1:0] in_col_r, in_col_nxt;
  logic [RW-1:0] in_row_r, in_row_nxt;
  logic          expecting;
  logic          ignore;
  logic          fend_item;

  // Item decode against the current raster position
  always_comb begin
    expecting  = (in_row_r <= h_last_r);
    ignore     = expecting && (in_ch.cmd == bmf_pkg::CMD_DRAIN);
    fend_item  = (in_row_r == RW'(h_last_r + RW'(2))) && (in_col_r == '0);
    item.value = expecting & in_ch.pixel_in;
    item.col0  = (in_col_r == '0);
    item.emit  = (in_row_r > RW'(1)) || ((in_row_r == RW'(1)) && (in_col_r != '0));
    item.fend  = fend_item;
  end

  assign in_ch.ready = stage_free;
  assign load        = in_ch.valid && stage_free && !ignore;
  assign addr        = in_col_r;
  assign w_last      = w_last_r;
  assign h_last      = h_last_r;

  // Register writes and raster position
  always_comb begin
    w_last_nxt = w_last_r;
    h_last_nxt = h_last_r;
    in_col_nxt = in_col_r;
    in_row_nxt = in_row_r;
    if (cfg_we) begin
      case (cfg_idx)
        bmf_pkg::REG_IMAGE_WIDTH: begin
          w_last_nxt = AW'(bmf_pkg::dim_last(
                         32'(cfg_wdata[bmf_pkg::WIDTH_FIELD_W-1:0]), 32'(MAX_COLS)));
        end
        bmf_pkg::REG_IMAGE_HEIGHT: begin
          h_last_nxt = RW'(bmf_pkg::dim_last(
                         32'(cfg_wdata[bmf_pkg::HEIGHT_FIELD_W-1:0]), 32'(MAX_ROWS)));
        end
        default: begin
        end
      endcase
      in_col_nxt = '0;
      in_row_nxt = '0;
    end else if (load) begin
      if (fend_item) begin
        in_col_nxt = '0;
        in_row_nxt = '0;
      end else if (in_col_r == w_last_r) begin
        in_col_nxt = '0;
        in_row_nxt = RW'(in_row_r + RW'(1));
      end else begin
        in_col_nxt = AW'(in_col_r + AW'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_last_r <= AW'(bmf_pkg::dim_last(32'(bmf_pkg::WIDTH_RST), 32'(MAX_COLS)));
      h_last_r <= RW'(bmf_pkg::dim_last(32'(bmf_pkg::HEIGHT_RST), 32'(MAX_ROWS)));
      in_col_r <= '0;
      in_row_r <= '0;
    end else begin
      w_last_r <= w_last_nxt;
      h_last_r <= h_last_nxt;
      in_col_r <= in_col_nxt;
      in_row_r <= in_row_nxt;
    end
  end

endmodule

FILE: rtl/bmf_core.sv
// Window stage: line store update, 3x3 window shift, majority vote and the
// result register. Depends on bmf_pkg, bmf_out_if and the assertion header.
`timescale 1ns / 1ps
`include "binary_majority_filter_3x3_unit_defines.svh"

module bmf_core #(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 64
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         cfg_clear,
  input  logic                                         load,
  input  bmf_pkg::item_t                               item,
  input  logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] addr,
  input  logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] w_last,
  input  logic [$clog2(MAX_ROWS + 2)-1:0]              h_last,
  input  logic [1:0]                                   mem_q,
  output logic                                         stage_free,
  output logic                                         mem_we,
  output logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] mem_waddr,
  output logic [1:0]                                   mem_wdata,
  bmf_out_if.source                                    out_ch
);

  localparam int AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RW = $clog2(MAX_ROWS + 2);
  localparam int WB = bmf_pkg::WIN_BITS;
  localparam int WD = bmf_pkg::WIN_DIM;
  localparam int CW = bmf_pkg::CNT_W;

  logic                 s1_valid_r, s1_valid_nxt;
  bmf_pkg::item_t       s1_item_r;
  logic [AW-1:0]        s1_addr_r;
  logic                 fwd_r;
  logic [1:0]           fwd_data_r;
  logic [WB-1:0]        win_r, win_nxt;
  logic [AW-1:0]        out_col_r, out_col_nxt;
  logic [RW-1:0]        out_row_r, out_row_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_pix_r, out_rend_r, out_fend_r;

  logic                 s1_adv;
  logic [1:0]           lines;
  logic [WB-1:0]        new_win;
  logic [WB-1:0]        nb;
  logic [WB-1:0]        mask;
  logic [WD-1:0]        row_ok, col_ok;
  logic [CW-1:0]        cnt, tot;
  logic                 pix, rend, fend;

  // Stage handshake: a result-less item moves on regardless of the output
  assign s1_adv     = s1_valid_r && (!s1_item_r.emit || !out_valid_r || out_ch.ready);
  assign stage_free = !s1_valid_r || s1_adv;

  // Line store data, with a bypass for a write that landed on the read edge
  assign lines     = fwd_r ? fwd_data_r : mem_q;
  assign mem_we    = s1_adv;
  assign mem_waddr = s1_addr_r;
  assign mem_wdata = {lines[0], s1_item_r.value};

  // Window shift: each row moves left, new column enters on the right
  always_comb begin
    logic [WD-1:0] col_bits;
    col_bits = {s1_item_r.value, lines[0], lines[1]};
    for (int r = 0; r < WD; r++) begin
      new_win[r*WD + 0] = win_r[r*WD + 1];
      new_win[r*WD + 1] = win_r[r*WD + 2];
      new_win[r*WD + 2] = col_bits[r];
    end
  end

  // Neighborhood and in-image mask around the output pixel
  always_comb begin
    for (int r = 0; r < WD; r++) begin
      if (s1_item_r.col0) begin
        // output is the last pixel of the previous row: old window, no right
        nb[r*WD + 0] = win_r[r*WD + 1];
        nb[r*WD + 1] = win_r[r*WD + 2];
        nb[r*WD + 2] = 1'b0;
      end else begin
        nb[r*WD + 0] = new_win[r*WD + 0];
        nb[r*WD + 1] = new_win[r*WD + 1];
        nb[r*WD + 2] = new_win[r*WD + 2];
      end
    end
    row_ok[0] = (out_row_r != '0);
    row_ok[1] = 1'b1;
    row_ok[2] = (out_row_r != h_last);
    col_ok[0] = (out_col_r != '0);
    col_ok[1] = 1'b1;
    col_ok[2] = !s1_item_r.col0 && (out_col_r != w_last);
    for (int r = 0; r < WD; r++) begin
      for (int j = 0; j < WD; j++) begin
        mask[r*WD + j] = row_ok[r] && col_ok[j];
      end
    end
  end

  // Majority vote over the in-image members
  always_comb begin
    cnt = '0;
    tot = '0;
    for (int i = 0; i < WB; i++) begin
      if (mask[i]) begin
        tot = CW'(tot + CW'(1));
        cnt = CW'(cnt + CW'(nb[i]));
      end
    end
    pix  = ({cnt, 1'b0} > {1'b0, tot});
    rend = (out_col_r == w_last);
    fend = rend && (out_row_r == RW'(h_last));
  end

  // Next state of stage, window, output position and result register
  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    win_nxt       = win_r;
    out_col_nxt   = out_col_r;
    out_row_nxt   = out_row_r;
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (s1_adv) begin
      s1_valid_nxt = 1'b0;
      win_nxt      = new_win;
      if (s1_item_r.emit) begin
        out_valid_nxt = 1'b1;
        if (fend) begin
          win_nxt     = '0;
          out_col_nxt = '0;
          out_row_nxt = '0;
        end else if (rend) begin
          out_col_nxt = '0;
          out_row_nxt = RW'(out_row_r + RW'(1));
        end else begin
          out_col_nxt = AW'(out_col_r + AW'(1));
        end
      end
    end
    if (load) begin
      s1_valid_nxt = 1'b1;
    end
    if (cfg_clear) begin
      s1_valid_nxt = 1'b0;
      win_nxt      = '0;
      out_col_nxt  = '0;
      out_row_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      win_r       <= '0;
      out_col_r   <= '0;
      out_row_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      win_r       <= win_nxt;
      out_col_r   <= out_col_nxt;
      out_row_r   <= out_row_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Stage payload and bypass capture
  always_ff @(posedge clk) begin
    if (load) begin
      s1_item_r  <= item;
      s1_addr_r  <= addr;
      fwd_r      <= s1_adv && (s1_addr_r == addr);
      fwd_data_r <= mem_wdata;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (s1_adv && s1_item_r.emit) begin
      out_pix_r  <= pix;
      out_rend_r <= rend;
      out_fend_r <= fend;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.pixel_out = out_pix_r;
  assign out_ch.row_end   = out_rend_r;
  assign out_ch.frame_end = out_fend_r;

  // Input-side frame end decode must agree with the output position
  `BMF_ASSERT_ALWAYS(a_fend_agree, !(s1_adv && s1_item_r.emit) || (fend == s1_item_r.fend), "frame end mismatch between input and output counters")
  // A released pixel reaches the result register
  `BMF_ASSERT_NEXT(a_emit_lands, s1_adv && s1_item_r.emit, out_valid_r, "result lost")
  // Window and output position restart after the last pixel of a frame
  `BMF_ASSERT_NEXT(a_frame_restart, s1_adv && s1_item_r.emit && fend, (win_r == '0) && (out_col_r == '0) && (out_row_r == '0), "frame did not restart")

endmodule

FILE: rtl/binary_majority_filter_3x3_unit.sv
// Top level of the 3x3 binary majority filter.
// Depends on bmf_pkg, bmf_in_if, bmf_out_if, bmf_scan, bmf_line_mem, bmf_core.
//
//  channel  | direction | handshake    | payload
//  in_ch    | in        | valid/ready  | cmd, pixel_in
//  out_ch   | out       | valid/ready  | pixel_out, row_end, frame_end
//  cfg_*    | in        | write enable | cfg_idx, cfg_wdata
//
// One item per clock while no held result stalls the stage. An accepted item
// is decoded against the raster counters and enters the window stage; the
// line store read is registered on the same edge. When the stage advances it
// updates the window and loads the result register behind out_ch.valid. Results
// lag the input by image_width+1 items; drain items flush the tail of a frame.
// Synchronous reset clears counters, window and valid flags; line stores hold
// no reset. A held result stalls the window stage and, through it, in_ch.
`timescale 1ns / 1ps

module binary_majority_filter_3x3_unit #(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  bmf_in_if.sink                         in_ch,
  bmf_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [bmf_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [bmf_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RW = $clog2(MAX_ROWS + 2);

  logic           stage_free;
  logic           load;
  bmf_pkg::item_t item;
  logic [AW-1:0]  addr;
  logic [AW-1:0]  w_last;
  logic [RW-1:0]  h_last;
  logic [1:0]     mem_q;
  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  logic [1:0]     mem_wdata;

  // Configuration and input raster counters
  bmf_scan #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .stage_free (stage_free),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .load       (load),
    .item       (item),
    .addr       (addr),
    .w_last     (w_last),
    .h_last     (h_last)
  );

  // Upper and middle line stores
  bmf_line_mem #(
    .DEPTH (MAX_COLS)
  ) u_lines (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (load),
    .raddr (addr),
    .rdata (mem_q)
  );

  // Window, vote and result register
  bmf_core #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_clear  (cfg_we),
    .load       (load),
    .item       (item),
    .addr       (addr),
    .w_last     (w_last),
    .h_last     (h_last),
    .mem_q      (mem_q),
    .stage_free (stage_free),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .out_ch     (out_ch)
  );

endmodule
